FILE: hdl/stfq_pkg.sv
// stfq_pkg: shared types, codes and defaults for the start-time fair queue scheduler
// no dependencies
`default_nettype none
package stfq_pkg;
  localparam int unsigned FLOW_COUNT_DEF  = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned TAG_W = 32;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned PKT_W = 8;
  localparam int unsigned FLOW_W = 3;
  localparam int unsigned OCC_W = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_LEN   = 2'd1;
  localparam logic [1:0] REG_FIXED = 2'd2;
  localparam logic [1:0] REG_MIN   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SCAN, S_SCAN_LAST, S_DEQ_RD, S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic [LEN_W-1:0] dividend;
    logic [WEIGHT_W-1:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

FILE: hdl/start_time_fair_queue_scheduler.sv
// start_time_fair_queue_scheduler: top level, per-flow ring queues scheduled by start tag
// depends on stfq_pkg and stfq_div
`default_nettype none
// One item at a time; busy is high from acceptance until its result strobe, and
// the next item can be accepted at the edge that takes the result. Enqueue waits
// on the 16-step serial divider forming packet_length / weight, then writes the
// entry and raises the strobe. Dequeue scans the flows, reading one flow's head
// start tag per cycle from the entry memory, then reads the winning entry. Load
// weights and the unused operation go straight to the strobe. The result is
// shown for one cycle on done and cannot be held off.
module start_time_fair_queue_scheduler #(
  parameter int unsigned FLOW_COUNT  = stfq_pkg::FLOW_COUNT_DEF,
  parameter int unsigned QUEUE_DEPTH = stfq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] operation,
  input  wire logic [stfq_pkg::FLOW_W-1:0] flow,
  input  wire logic [stfq_pkg::PKT_W-1:0] packet_index,
  input  wire logic [stfq_pkg::WEIGHT_W-1:0] weight,
  input  wire logic [stfq_pkg::WEIGHT_W-1:0] weight_sum_in,
  input  wire logic [stfq_pkg::TAG_W-1:0] now,
  input  wire logic cfg_we,
  input  wire logic [stfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [stfq_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic done,
  output logic [1:0] status,
  output logic [stfq_pkg::PKT_W-1:0] out_packet_index,
  output logic [stfq_pkg::FLOW_W-1:0] out_flow,
  output logic [stfq_pkg::WEIGHT_W-1:0] weight_sum,
  output logic [stfq_pkg::OCC_W-1:0] occupancy
);
  localparam int unsigned FI_W = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
  localparam int unsigned QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRIES = FLOW_COUNT * QUEUE_DEPTH;
  localparam int unsigned EA_W = $clog2(ENTRIES);
  localparam int unsigned TOT_W = $clog2(ENTRIES + 1);
  localparam int unsigned TAG_W = stfq_pkg::TAG_W;
  localparam int unsigned WW = stfq_pkg::WEIGHT_W;
  localparam int unsigned PW = stfq_pkg::PKT_W;
  localparam int unsigned ENT_W = TAG_W + PW + WW;

  // configuration
  logic weight_mode;
  logic [stfq_pkg::LEN_W-1:0] packet_length;
  logic [WW-1:0] fixed_sum_weight, min_sum_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mode <= 1'b1;
      packet_length <= stfq_pkg::LEN_W'(100);
      fixed_sum_weight <= WW'(1);
      min_sum_weight <= WW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        stfq_pkg::REG_MODE:  weight_mode <= cfg_data[0];
        stfq_pkg::REG_LEN:   packet_length <= cfg_data;
        stfq_pkg::REG_FIXED: fixed_sum_weight <= cfg_data;
        stfq_pkg::REG_MIN:   min_sum_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-flow control state (small, reset)
  logic [QP_W-1:0] wr_ptr [FLOW_COUNT];
  logic [QP_W-1:0] rd_ptr [FLOW_COUNT];
  logic [QC_W-1:0] fcount [FLOW_COUNT];
  logic [TAG_W-1:0] last_finish [FLOW_COUNT];
  logic [WW-1:0] flow_wt [FLOW_COUNT];
  logic [WW-1:0] running_total;
  logic [TOT_W-1:0] total_queued;

  // entry memory: {start tag, packet, weight}
  logic [ENT_W-1:0] entry_mem [ENTRIES];
  logic mem_we;
  logic [EA_W-1:0] mem_waddr, mem_raddr;
  logic [ENT_W-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= entry_mem[mem_raddr];
  end

  // latched item
  logic [1:0] op_q;
  logic [FI_W-1:0] flow_q;
  logic flow_bad_q;
  logic [PW-1:0] pkt_q;
  logic [WW-1:0] w_q, tot_q;
  logic [TAG_W-1:0] now_q;

  stfq_pkg::state_t state, state_next;
  logic [FI_W:0] scan_idx;
  logic best_found;
  logic [TAG_W-1:0] best_tag;
  logic [FI_W-1:0] best_flow;
  logic [FI_W-1:0] rd_flow;
  logic rd_valid;
  logic cand_take;
  logic [FI_W-1:0] best_flow_nx;
  logic enq_ok;

  stfq_pkg::div_req_t dreq;
  logic [stfq_pkg::LEN_W-1:0] dquo;
  logic ddone;

  stfq_div u_div (.clk(clk), .rst(rst), .req(dreq), .quotient(dquo), .done(ddone));

  logic accept;
  assign accept = start && !busy;
  assign busy = (state != stfq_pkg::S_IDLE);

  logic [TAG_W-1:0] start_stamp;
  assign start_stamp = (now_q > last_finish[flow_q]) ? now_q : last_finish[flow_q];

  assign enq_ok = !flow_bad_q && (fcount[flow_q] < QC_W'(QUEUE_DEPTH)) && (w_q != '0);

  always_comb begin
    state_next = state;
    case (state)
      stfq_pkg::S_IDLE: begin
        if (accept) begin
          case (operation)
            stfq_pkg::OP_ENQ:  state_next = stfq_pkg::S_DIV;
            stfq_pkg::OP_DEQ:  state_next = stfq_pkg::S_SCAN;
            default:           state_next = stfq_pkg::S_DONE;
          endcase
        end
      end
      stfq_pkg::S_DIV:       if (ddone) state_next = stfq_pkg::S_DONE;
      stfq_pkg::S_SCAN:
        if (scan_idx == (FI_W+1)'(FLOW_COUNT - 1)) state_next = stfq_pkg::S_SCAN_LAST;
      stfq_pkg::S_SCAN_LAST: state_next = stfq_pkg::S_DEQ_RD;
      stfq_pkg::S_DEQ_RD:    state_next = stfq_pkg::S_DONE;
      stfq_pkg::S_DONE:      state_next = stfq_pkg::S_IDLE;
      default:               state_next = stfq_pkg::S_IDLE;
    endcase
  end

  // scan compare of the tag read last cycle
  always_comb begin
    cand_take = rd_valid && (!best_found || mem_rdata[ENT_W-1 -: TAG_W] < best_tag);
    best_flow_nx = cand_take ? rd_flow : best_flow;
  end

  // memory address and write
  always_comb begin
    mem_raddr = '0;
    if (state == stfq_pkg::S_SCAN)
      mem_raddr = EA_W'(scan_idx[FI_W-1:0] * QUEUE_DEPTH + rd_ptr[scan_idx[FI_W-1:0]]);
    else if (state == stfq_pkg::S_SCAN_LAST)
      mem_raddr = EA_W'(best_flow_nx * QUEUE_DEPTH + rd_ptr[best_flow_nx]);
    mem_we = (state == stfq_pkg::S_DIV) && ddone && enq_ok;
    mem_waddr = EA_W'(flow_q * QUEUE_DEPTH + wr_ptr[flow_q]);
    mem_wdata = {start_stamp, pkt_q, w_q};
  end

  always_comb begin
    dreq.start = (state == stfq_pkg::S_IDLE) && accept && (operation == stfq_pkg::OP_ENQ);
    dreq.dividend = packet_length;
    dreq.divisor = (weight == '0) ? WW'(1) : weight;
  end

  logic [WW-1:0] rt_upd;
  assign rt_upd = running_total - flow_wt[best_flow] + mem_rdata[WW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stfq_pkg::S_IDLE;
      done <= 1'b0;
      running_total <= '0;
      total_queued <= '0;
      for (int i = 0; i < FLOW_COUNT; i++) begin
        wr_ptr[i] <= '0;
        rd_ptr[i] <= '0;
        fcount[i] <= '0;
        last_finish[i] <= '0;
        flow_wt[i] <= '0;
      end
      scan_idx <= '0;
      best_found <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      case (state)
        stfq_pkg::S_IDLE: begin
          if (accept) begin
            op_q <= operation;
            flow_q <= FI_W'(flow);
            flow_bad_q <= ({29'd0, flow} >= FLOW_COUNT);
            pkt_q <= packet_index;
            w_q <= weight;
            tot_q <= weight_sum_in;
            now_q <= now;
            scan_idx <= '0;
            best_found <= 1'b0;
            best_flow <= '0;
            rd_valid <= 1'b0;
            status <= stfq_pkg::ST_OK;
            out_packet_index <= '0;
            out_flow <= '0;
          end
        end
        stfq_pkg::S_DIV: begin
          if (ddone) begin
            if (flow_bad_q || fcount[flow_q] >= QC_W'(QUEUE_DEPTH))
              status <= stfq_pkg::ST_FULL;
            else if (w_q == '0)
              status <= stfq_pkg::ST_ZERO;
            if (enq_ok) begin
              last_finish[flow_q] <= start_stamp + TAG_W'(dquo);
              wr_ptr[flow_q] <= (wr_ptr[flow_q] == QP_W'(QUEUE_DEPTH - 1)) ? '0
                                : wr_ptr[flow_q] + 1'b1;
              fcount[flow_q] <= fcount[flow_q] + 1'b1;
              total_queued <= total_queued + 1'b1;
            end
          end
        end
        stfq_pkg::S_SCAN, stfq_pkg::S_SCAN_LAST: begin
          if (cand_take) begin
            best_found <= 1'b1;
            best_tag <= mem_rdata[ENT_W-1 -: TAG_W];
          end
          best_flow <= best_flow_nx;
          if (state == stfq_pkg::S_SCAN) begin
            rd_flow <= scan_idx[FI_W-1:0];
            rd_valid <= (fcount[scan_idx[FI_W-1:0]] != '0);
            scan_idx <= scan_idx + 1'b1;
          end
        end
        stfq_pkg::S_DEQ_RD: begin
          // mem_rdata now holds the winning head entry
          if (!best_found) begin
            status <= stfq_pkg::ST_EMPTY;
          end else begin
            out_packet_index <= mem_rdata[WW +: PW];
            out_flow <= stfq_pkg::FLOW_W'(best_flow);
            rd_ptr[best_flow] <= (rd_ptr[best_flow] == QP_W'(QUEUE_DEPTH - 1)) ? '0
                                 : rd_ptr[best_flow] + 1'b1;
            fcount[best_flow] <= fcount[best_flow] - 1'b1;
            total_queued <= total_queued - 1'b1;
            if (weight_mode) begin
              running_total <= rt_upd;
              flow_wt[best_flow] <= mem_rdata[WW-1:0];
            end
          end
        end
        stfq_pkg::S_DONE: begin
          done <= 1'b1;
          if (op_q == stfq_pkg::OP_LOAD) begin
            for (int i = 0; i < FLOW_COUNT; i++) flow_wt[i] <= w_q;
            running_total <= tot_q;
          end
        end
        default: ;
      endcase
    end
  end

  // load weights lands with the strobe, so fold it into the reported total
  logic [WW-1:0] rt_view;
  assign rt_view = (state == stfq_pkg::S_DONE && op_q == stfq_pkg::OP_LOAD) ? tot_q
                                                                              : running_total;
  always_ff @(posedge clk) begin
    if (state == stfq_pkg::S_DONE) begin
      weight_sum <= !weight_mode ? fixed_sum_weight :
                    (rt_view < min_sum_weight ? min_sum_weight : rt_view);
      occupancy <= stfq_pkg::OCC_W'(total_queued);
    end
  end

  // status/total shown on done must be registered from S_DONE; hold strobe aligned
  assert property (@(posedge clk) disable iff (rst) done |-> state == stfq_pkg::S_IDLE)
    else $error("done outside idle");
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("done without item");
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> fcount[flow_q] < QC_W'(QUEUE_DEPTH))
    else $error("write into full flow");
  assert property (@(posedge clk) disable iff (rst) total_queued <= TOT_W'(ENTRIES))
    else $error("occupancy overflow");
endmodule
`default_nettype wire

FILE: hdl/stfq_div.sv
// stfq_div: radix-2 restoring divider, one quotient bit per cycle
// depends on stfq_pkg
`default_nettype none
module stfq_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire stfq_pkg::div_req_t req,
  output logic [stfq_pkg::LEN_W-1:0] quotient,
  output logic done
);
  localparam int unsigned N = stfq_pkg::LEN_W;
  localparam int unsigned CW = $clog2(N + 1);
  logic [N:0] rem;
  logic [N-1:0] quo;
  logic [stfq_pkg::WEIGHT_W-1:0] dvs;
  logic [CW-1:0] cnt;
  logic busy;
  logic [N:0] trial;
  logic [N:0] diff;

  always_comb begin
    trial = {rem[N-1:0], quo[N-1]};
    diff = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CW'(N);
        rem <= '0;
        quo <= req.dividend;
        dvs <= req.divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= diff;
          quo <= {quo[N-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[N-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
endmodule
`default_nettype wire

FILE: tb/tb_start_time_fair_queue_scheduler.sv
// tb_start_time_fair_queue_scheduler: self-checking bench for the start-time fair queue scheduler
// depends on stfq_pkg and the scheduler rtl; a scoreboard class predicts each result beat
`timescale 1ns / 1ps
`default_nettype none

module tb_start_time_fair_queue_scheduler;

  localparam int FLOWS = 8;
  localparam int DEPTH = 8;

  typedef struct packed {
    logic [1:0] status;
    logic [stfq_pkg::PKT_W-1:0] pkt;
    logic [stfq_pkg::FLOW_W-1:0] flw;
    logic [stfq_pkg::WEIGHT_W-1:0] tot;
    logic [stfq_pkg::OCC_W-1:0] occ;
  } sched_result_t;

  class sched_scoreboard;
    bit mode;
    bit [15:0] pkt_len, fixed_tot, min_tot;
    bit [2:0] wr_ptr[FLOWS], rd_ptr[FLOWS];
    int unsigned depth_of[FLOWS];
    bit [31:0] fin_stamp[FLOWS];
    bit [31:0] entry_stamp[FLOWS*DEPTH];
    bit [7:0] pkt_mem[FLOWS*DEPTH];
    bit [15:0] wt_mem[FLOWS*DEPTH];
    bit [15:0] flow_wt[FLOWS];
    bit [15:0] run_tot;
    sched_result_t pending[$];
    int errors;

    function new();
      mode = 1; pkt_len = 100; fixed_tot = 1; min_tot = 1;
      run_tot = 0; errors = 0;
      for (int f = 0; f < FLOWS; f++) begin
        wr_ptr[f] = 0; rd_ptr[f] = 0; depth_of[f] = 0;
        fin_stamp[f] = 0; flow_wt[f] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        stfq_pkg::REG_MODE: mode = val[0];
        stfq_pkg::REG_LEN: pkt_len = val;
        stfq_pkg::REG_FIXED: fixed_tot = val;
        stfq_pkg::REG_MIN: min_tot = val;
        default: ;
      endcase
    endfunction

    function int unsigned queued();
      int unsigned s;
      s = 0;
      for (int f = 0; f < FLOWS; f++) s += depth_of[f];
      return s;
    endfunction

    function void note_beat(logic [1:0] op, logic [2:0] fl, logic [7:0] pk,
                            logic [15:0] w, logic [15:0] tin, logic [31:0] tick);
      sched_result_t r;
      bit found;
      bit [31:0] best, st;
      int bf, slot;
      r = '0;
      r.status = stfq_pkg::ST_OK;
      if (op == stfq_pkg::OP_ENQ) begin
        if (depth_of[fl] >= DEPTH) r.status = stfq_pkg::ST_FULL;
        else if (w == 0) r.status = stfq_pkg::ST_ZERO;
        else begin
          slot = fl * DEPTH + wr_ptr[fl];
          st = tick > fin_stamp[fl] ? tick : fin_stamp[fl];
          entry_stamp[slot] = st; pkt_mem[slot] = pk; wt_mem[slot] = w;
          fin_stamp[fl] = st + 32'(pkt_len / w);
          wr_ptr[fl]++; depth_of[fl]++;
        end
      end else if (op == stfq_pkg::OP_DEQ) begin
        found = 0; best = 0; bf = 0;
        for (int f = 0; f < FLOWS; f++)
          if (depth_of[f] != 0) begin
            st = entry_stamp[f * DEPTH + rd_ptr[f]];
            if (!found || st < best) begin
              found = 1; best = st; bf = f;
            end
          end
        if (!found) r.status = stfq_pkg::ST_EMPTY;
        else begin
          slot = bf * DEPTH + rd_ptr[bf];
          r.pkt = pkt_mem[slot]; r.flw = stfq_pkg::FLOW_W'(bf);
          rd_ptr[bf]++; depth_of[bf]--;
          if (mode) begin
            run_tot = run_tot - flow_wt[bf] + wt_mem[slot];
            flow_wt[bf] = wt_mem[slot];
          end
        end
      end else if (op == stfq_pkg::OP_LOAD) begin
        for (int f = 0; f < FLOWS; f++) flow_wt[f] = w;
        run_tot = tin;
      end
      r.tot = !mode ? fixed_tot : (run_tot < min_tot ? min_tot : run_tot);
      r.occ = stfq_pkg::OCC_W'(queued());
      pending.push_back(r);
    endfunction

    function void check_beat(sched_result_t got);
      sched_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status); errors++;
      end
      if (got.pkt !== exp_r.pkt) begin
        $error("out_packet_index: expected %0d, got %0d", exp_r.pkt, got.pkt); errors++;
      end
      if (got.flw !== exp_r.flw) begin
        $error("out_flow: expected %0d, got %0d", exp_r.flw, got.flw); errors++;
      end
      if (got.tot !== exp_r.tot) begin
        $error("weight_sum: expected %0d, got %0d", exp_r.tot, got.tot); errors++;
      end
      if (got.occ !== exp_r.occ) begin
        $error("occupancy: expected %0d, got %0d", exp_r.occ, got.occ); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0, busy, cfg_we = 0, done;
  logic [1:0] operation = 0, cfg_index = 0, status;
  logic [2:0] flow = 0, out_flow;
  logic [7:0] packet_index = 0, out_packet_index;
  logic [15:0] weight = 0, weight_sum_in = 0, cfg_data = 0, weight_sum;
  logic [31:0] now = 0;
  logic [6:0] occupancy;

  sched_scoreboard sb;
  int beats_in, beats_out;
  int enq_bias;
  logic [31:0] tick;

  start_time_fair_queue_scheduler i_dut (
    .clk, .rst, .start, .busy, .operation, .flow, .packet_index, .weight,
    .weight_sum_in, .now, .cfg_we, .cfg_index, .cfg_data, .done, .status,
    .out_packet_index, .out_flow, .weight_sum, .occupancy
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("tb_start_time_fair_queue_scheduler: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_beat({status, out_packet_index, out_flow, weight_sum, occupancy});
      beats_out++;
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
  endtask

  // send one beat; holds start until accepted
  task automatic send(logic [1:0] op, logic [2:0] fl, logic [7:0] pk,
                      logic [15:0] w, logic [15:0] tin, logic [31:0] tk, int gap);
    @(negedge clk);
    repeat (gap) @(negedge clk);
    start <= 1; operation <= op; flow <= fl; packet_index <= pk;
    weight <= w; weight_sum_in <= tin; now <= tk;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_beat(op, fl, pk, w, tin, tk);
    beats_in++;
    @(negedge clk);
    start <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic random_beat();
    int r;
    logic [1:0] op;
    logic [15:0] w;
    r = $urandom_range(99);
    op = r < enq_bias ? stfq_pkg::OP_ENQ :
         (r < 94 ? stfq_pkg::OP_DEQ : (r < 98 ? stfq_pkg::OP_LOAD : stfq_pkg::OP_NONE));
    w = ($urandom_range(9) == 0) ? 16'd0 :
        ($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 20)));
    tick += $urandom_range(0, 50);
    if ($urandom_range(39) == 0) tick = $urandom;
    send(op, 3'($urandom), 8'($urandom), w, 16'($urandom), tick,
         $urandom_range(3) == 0 ? $urandom_range(0, 14) : 0);
  endtask

  initial begin
    sb = new();
    beats_in = 0; beats_out = 0; tick = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    repeat (2) @(negedge clk);

    // directed: empty dequeue, zero weight, maximal tags, full flow, extremes
    send(stfq_pkg::OP_DEQ, 0, 0, 0, 0, 0, 0);
    send(stfq_pkg::OP_ENQ, 2, 8'hFF, 16'd0, 0, 0, 0);
    send(stfq_pkg::OP_ENQ, 7, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
    send(stfq_pkg::OP_ENQ, 0, 8'h00, 16'd1, 0, 32'hFFFF_FFF0, 0);
    send(stfq_pkg::OP_ENQ, 3, 8'h5A, 16'd1, 0, 32'hFFFF_FFFF, 0);
    for (int i = 0; i < 9; i++) send(stfq_pkg::OP_ENQ, 5, 8'(i), 16'd3, 0, 32'd10, 0);
    send(stfq_pkg::OP_NONE, 7, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
    send(stfq_pkg::OP_LOAD, 0, 0, 16'hFFFF, 16'h0000, 0, 0);
    for (int i = 0; i < 4; i++) send(stfq_pkg::OP_DEQ, 0, 0, 0, 0, 0, 0);
    drain();

    write_cfg(stfq_pkg::REG_LEN, 16'd0);
    write_cfg(stfq_pkg::REG_MIN, 16'hFFFF);
    send(stfq_pkg::OP_ENQ, 1, 8'h11, 16'd7, 0, 32'd0, 0);
    send(stfq_pkg::OP_DEQ, 0, 0, 0, 0, 0, 0);
    send(stfq_pkg::OP_LOAD, 0, 0, 16'd0, 16'hFFFF, 0, 0);
    drain();
    write_cfg(stfq_pkg::REG_MODE, 16'd0);
    write_cfg(stfq_pkg::REG_FIXED, 16'hFFFF);
    write_cfg(stfq_pkg::REG_LEN, 16'hFFFF);
    write_cfg(stfq_pkg::REG_MIN, 16'd0);
    for (int i = 0; i < 20; i++) send(stfq_pkg::OP_DEQ, 0, 0, 0, 0, 0, 0);
    drain();

    // random phases with different settings and fill/drain balance
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(stfq_pkg::REG_MODE, 16'(ph % 2));
      write_cfg(stfq_pkg::REG_LEN, ph == 2 ? 16'd1 : (ph == 4 ? 16'hFFFF : 16'($urandom)));
      write_cfg(stfq_pkg::REG_FIXED, ph == 3 ? 16'd0 : 16'($urandom));
      write_cfg(stfq_pkg::REG_MIN, ph == 5 ? 16'hFFFF : 16'($urandom_range(0, 300)));
      enq_bias = (ph % 3 == 0) ? 70 : ((ph % 3 == 1) ? 50 : 35);
      for (int i = 0; i < 90; i++) random_beat();
      drain();
    end

    $display("covered %0d beats sent, %0d results checked, over fixed and adaptive totals",
             beats_in, beats_out);
    if (sb.errors == 0) $display("tb_start_time_fair_queue_scheduler: done, clean");
    else $display("tb_start_time_fair_queue_scheduler: done, errors");
    $finish;
  end
endmodule

`default_nettype wire

FILE: filelist.f
hdl/stfq_pkg.sv
hdl/stfq_div.sv
hdl/start_time_fair_queue_scheduler.sv
tb/tb_start_time_fair_queue_scheduler.sv
